[rtl/circle_distance_normal_defines.svh]
// Assertion macros for the circle distance and normal block.
`ifndef CIRCLE_DISTANCE_NORMAL_DEFINES_SVH
`define CIRCLE_DISTANCE_NORMAL_DEFINES_SVH

// same-cycle implication
`define CDN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdn check failed");

// next-cycle implication
`define CDN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdn check failed");

`endif

[rtl/cdn_pkg.sv]
// Types, constants and step functions shared by the circle distance pipeline.
package cdn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQ_STEPS  = 34;
  localparam int DIV_STEPS = 32;
  localparam int NRM_STEPS = FRAC_BITS + 1;

  localparam logic [31:0] CENTER_RESET = 32'(1 << (FRAC_BITS - 1));
  localparam logic [30:0] RADIUS_RESET = 31'((1 << FRAC_BITS) / 5);

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } pt_in_t;

  typedef struct packed {
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic               outside;
  } pt_out_t;

  // digit-by-digit square root state
  typedef struct packed {
    logic [67:0] rad;
    logic [35:0] rem;
    logic [33:0] root;
  } sq_t;

  // restoring divider state
  typedef struct packed {
    logic [33:0] d;
    logic [33:0] rem;
    logic [31:0] feed;
    logic [31:0] quo;
  } dv_t;

  typedef struct packed {
    logic [31:0]        num_x;
    logic [31:0]        num_y;
    logic [31:0]        dvsr;
    logic               neg_x;
    logic               neg_y;
    logic               zero;
    logic               outside;
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
  } nrm_in_t;

  function automatic sq_t sq_step(input sq_t s);
    sq_t         o;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    rem_sh = {s.rem[33:0], s.rad[67:66]};
    trial  = {s.root, 2'b01};
    o.rad  = {s.rad[65:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[32:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[32:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t dv_step(input dv_t s);
    dv_t         o;
    logic [34:0] t;
    t      = {s.rem, s.feed[31]};
    o.d    = s.d;
    o.feed = {s.feed[30:0], 1'b0};
    if (t >= {1'b0, s.d}) begin
      o.rem = 34'(t - {1'b0, s.d});
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = t[33:0];
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [31:0] sat32(input logic neg, input logic [32:0] mag);
    logic [31:0] v;
    if (neg) begin
      v = (mag >= 33'h080000000) ? 32'h80000000 : 32'(-mag[31:0]);
    end else begin
      v = (mag >= 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return $signed(v);
  endfunction

endpackage

[rtl/cdn_normal_pipe.sv]
// Normal division pipeline, saturation and output register.
module cdn_normal_pipe (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_in,
  input  cdn_pkg::nrm_in_t nin,
  output logic             vld_out,
  output cdn_pkg::pt_out_t res
);
  import cdn_pkg::*;

  localparam int STG = NRM_STEPS + 2;

  typedef struct packed {
    dv_t                qx;
    dv_t                qy;
    logic               neg_x;
    logic               neg_y;
    logic               zero;
    logic               outside;
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
  } nc_t;

  logic [STG-1:0] vld;
  nrm_in_t        j_st;
  nc_t            q [NRM_STEPS];
  nc_t            q0;

  always_comb begin
    q0.qx.d    = {2'b00, j_st.dvsr};
    q0.qx.rem  = {3'b000, j_st.num_x[31:1]};
    q0.qx.feed = {j_st.num_x[0], 31'b0};
    q0.qx.quo  = '0;
    q0.qy.d    = {2'b00, j_st.dvsr};
    q0.qy.rem  = {3'b000, j_st.num_y[31:1]};
    q0.qy.feed = {j_st.num_y[0], 31'b0};
    q0.qy.quo  = '0;
    q0.neg_x   = j_st.neg_x;
    q0.neg_y   = j_st.neg_y;
    q0.zero    = j_st.zero;
    q0.outside = j_st.outside;
    q0.dist_x  = j_st.dist_x;
    q0.dist_y  = j_st.dist_y;
  end

  function automatic nc_t nc_adv(input nc_t x);
    nc_t o;
    o    = x;
    o.qx = dv_step(x.qx);
    o.qy = dv_step(x.qy);
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STG-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_st <= nin;
      q[0] <= nc_adv(q0);
      for (int i = 1; i < NRM_STEPS; i++) begin
        q[i] <= nc_adv(q[i-1]);
      end
      res.dist_x  <= q[NRM_STEPS-1].dist_x;
      res.dist_y  <= q[NRM_STEPS-1].dist_y;
      res.outside <= q[NRM_STEPS-1].outside;
      if (q[NRM_STEPS-1].zero) begin
        res.normal_x <= '0;
        res.normal_y <= '0;
      end else begin
        res.normal_x <= sat32(q[NRM_STEPS-1].neg_x,
                              33'(q[NRM_STEPS-1].qx.quo[NRM_STEPS-1:0]));
        res.normal_y <= sat32(q[NRM_STEPS-1].neg_y,
                              33'(q[NRM_STEPS-1].qy.quo[NRM_STEPS-1:0]));
      end
    end
  end

  assign vld_out = vld[STG-1];

endmodule

[rtl/circle_distance_normal.sv]
// Pipeline: one stage per root bit and per quotient bit in the two square roots
// and two divisions.
// Throughput: one transfer per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: synchronous, clears all valid bits; center and radius return to
// 0.5, 0.5 and about 0.2.
`include "circle_distance_normal_defines.svh"

module circle_distance_normal (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  cdn_pkg::pt_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cdn_pkg::pt_out_t out_data
);
  import cdn_pkg::*;

  localparam int TOP_STG = 3 + SQ_STEPS + 1 + DIV_STEPS + 3 + SQ_STEPS;

  typedef struct packed {
    sq_t         s;
    logic [32:0] mx;
    logic [32:0] my;
    logic        pos_x;
    logic        pos_y;
  } s1_t;

  typedef struct packed {
    dv_t         qx;
    dv_t         qy;
    logic [31:0] mx;
    logic [31:0] my;
    logic        pos_x;
    logic        pos_y;
    logic        outside;
  } s2_t;

  typedef struct packed {
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        mx;
    logic [31:0]        my;
    logic               pos_x;
    logic               pos_y;
    logic               outside;
  } s3_t;

  typedef struct packed {
    sq_t s;
    s3_t b;
  } s4_t;

  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0]        circle_radius;

  logic               en;
  logic [TOP_STG-1:0] vld;

  logic signed [32:0] a_dx, a_dy;
  logic [32:0]        a_mx, a_my;
  logic [65:0]        b_sqx, b_sqy;
  logic [32:0]        b_mx, b_my;
  logic               b_px, b_py;
  s1_t                c_st;
  s1_t                s1 [SQ_STEPS];
  logic [33:0]        d_r;
  logic               d_out;
  logic [66:0]        d_prx, d_pry;
  logic [31:0]        d_mx, d_my;
  logic               d_px, d_py;
  s2_t                s2_0;
  s2_t                s2 [DIV_STEPS];
  s3_t                f_st;
  s3_t                g_st;
  logic [63:0]        g_sqx, g_sqy;
  s4_t                h_st;
  s4_t                s4 [SQ_STEPS];

  logic               j_outside;
  logic [33:0]        j_r;
  logic [33:0]        j_gap;
  logic signed [31:0] f_dx, f_dy;
  nrm_in_t            nin;
  logic               nvld;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= CENTER_RESET;
      center_y      <= CENTER_RESET;
      circle_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: center_x      <= cfg_data;
        REG_CENTER_Y: center_y      <= cfg_data;
        REG_RADIUS:   circle_radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOP_STG-2:0], in_valid};
    end
  end

  function automatic s1_t s1_adv(input s1_t x);
    s1_t o;
    o   = x;
    o.s = sq_step(x.s);
    return o;
  endfunction

  function automatic s2_t s2_adv(input s2_t x);
    s2_t o;
    o    = x;
    o.qx = dv_step(x.qx);
    o.qy = dv_step(x.qy);
    return o;
  endfunction

  function automatic s4_t s4_adv(input s4_t x);
    s4_t o;
    o   = x;
    o.s = sq_step(x.s);
    return o;
  endfunction

  always_comb begin
    a_mx = a_dx[32] ? 33'(-a_dx) : a_dx;
    a_my = a_dy[32] ? 33'(-a_dy) : a_dy;

    j_r       = s1[SQ_STEPS-1].s.root;
    j_outside = j_r > {3'b000, circle_radius};
    j_gap     = j_r - {3'b000, circle_radius};

    s2_0.qx.d    = d_r;
    s2_0.qx.rem  = d_prx[65:32];
    s2_0.qx.feed = d_prx[31:0];
    s2_0.qx.quo  = '0;
    s2_0.qy.d    = d_r;
    s2_0.qy.rem  = d_pry[65:32];
    s2_0.qy.feed = d_pry[31:0];
    s2_0.qy.quo  = '0;
    s2_0.mx      = d_mx;
    s2_0.my      = d_my;
    s2_0.pos_x   = d_px;
    s2_0.pos_y   = d_py;
    s2_0.outside = d_out;

    f_dx = s2[DIV_STEPS-1].outside ?
           sat32(s2[DIV_STEPS-1].pos_x, {1'b0, s2[DIV_STEPS-1].qx.quo}) : '0;
    f_dy = s2[DIV_STEPS-1].outside ?
           sat32(s2[DIV_STEPS-1].pos_y, {1'b0, s2[DIV_STEPS-1].qy.quo}) : '0;

    nin.outside = s4[SQ_STEPS-1].b.outside;
    nin.dist_x  = s4[SQ_STEPS-1].b.dist_x;
    nin.dist_y  = s4[SQ_STEPS-1].b.dist_y;
    if (s4[SQ_STEPS-1].b.outside) begin
      nin.num_x = s4[SQ_STEPS-1].b.ax;
      nin.num_y = s4[SQ_STEPS-1].b.ay;
      nin.dvsr  = s4[SQ_STEPS-1].s.root[31:0];
      nin.neg_x = s4[SQ_STEPS-1].b.dist_x[31];
      nin.neg_y = s4[SQ_STEPS-1].b.dist_y[31];
      nin.zero  = s4[SQ_STEPS-1].s.root == '0;
    end else begin
      nin.num_x = s4[SQ_STEPS-1].b.mx;
      nin.num_y = s4[SQ_STEPS-1].b.my;
      nin.dvsr  = (circle_radius == '0) ? 32'd1 : {1'b0, circle_radius};
      nin.neg_x = s4[SQ_STEPS-1].b.pos_x;
      nin.neg_y = s4[SQ_STEPS-1].b.pos_y;
      nin.zero  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= $signed({in_data.point_x[31], in_data.point_x}) -
              $signed({center_x[31], center_x});
      a_dy <= $signed({in_data.point_y[31], in_data.point_y}) -
              $signed({center_y[31], center_y});

      b_sqx <= {33'b0, a_mx} * {33'b0, a_mx};
      b_sqy <= {33'b0, a_my} * {33'b0, a_my};
      b_mx  <= a_mx;
      b_my  <= a_my;
      b_px  <= !a_dx[32] && (a_dx != '0);
      b_py  <= !a_dy[32] && (a_dy != '0);

      c_st.s.rad  <= {1'b0, 67'(b_sqx) + 67'(b_sqy)};
      c_st.s.rem  <= '0;
      c_st.s.root <= '0;
      c_st.mx     <= b_mx;
      c_st.my     <= b_my;
      c_st.pos_x  <= b_px;
      c_st.pos_y  <= b_py;

      s1[0] <= s1_adv(c_st);
      for (int i = 1; i < SQ_STEPS; i++) begin
        s1[i] <= s1_adv(s1[i-1]);
      end

      d_r   <= j_r;
      d_out <= j_outside;
      d_prx <= {34'b0, s1[SQ_STEPS-1].mx} * {33'b0, j_gap};
      d_pry <= {34'b0, s1[SQ_STEPS-1].my} * {33'b0, j_gap};
      d_mx  <= s1[SQ_STEPS-1].mx[31:0];
      d_my  <= s1[SQ_STEPS-1].my[31:0];
      d_px  <= s1[SQ_STEPS-1].pos_x;
      d_py  <= s1[SQ_STEPS-1].pos_y;

      s2[0] <= s2_adv(s2_0);
      for (int i = 1; i < DIV_STEPS; i++) begin
        s2[i] <= s2_adv(s2[i-1]);
      end

      f_st.dist_x  <= f_dx;
      f_st.dist_y  <= f_dy;
      f_st.ax      <= f_dx[31] ? 32'(-f_dx) : f_dx;
      f_st.ay      <= f_dy[31] ? 32'(-f_dy) : f_dy;
      f_st.mx      <= s2[DIV_STEPS-1].mx;
      f_st.my      <= s2[DIV_STEPS-1].my;
      f_st.pos_x   <= s2[DIV_STEPS-1].pos_x;
      f_st.pos_y   <= s2[DIV_STEPS-1].pos_y;
      f_st.outside <= s2[DIV_STEPS-1].outside;

      g_st  <= f_st;
      g_sqx <= {32'b0, f_st.ax} * {32'b0, f_st.ax};
      g_sqy <= {32'b0, f_st.ay} * {32'b0, f_st.ay};

      h_st.s.rad  <= {4'b0000, g_sqx + g_sqy};
      h_st.s.rem  <= '0;
      h_st.s.root <= '0;
      h_st.b      <= g_st;

      s4[0] <= s4_adv(h_st);
      for (int i = 1; i < SQ_STEPS; i++) begin
        s4[i] <= s4_adv(s4[i-1]);
      end
    end
  end

  cdn_normal_pipe u_nrm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (vld[TOP_STG-1]),
    .nin     (nin),
    .vld_out (nvld),
    .res     (out_data)
  );

  assign out_valid = nvld;

  `CDN_ASSERT_NXT(a_xfer_enters, clk, rst, in_valid && in_ready, vld[0])
  `CDN_ASSERT_NXT(a_stall_holds, clk, rst, !in_ready, out_valid)
  `CDN_ASSERT_IMP(a_inside_zero, clk, rst, out_valid && !out_data.outside,
                  out_data.dist_x == '0 && out_data.dist_y == '0)
  `CDN_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

endmodule
